// ----- rtl/core/pic_pkg.sv -----
// Shared types and constants for the platform interrupt controller.
// Holds the register map, operation and state codes and the response struct.
// No dependencies.
package pic_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned OFF_W  = 26;
    localparam int unsigned SRC_W  = 10;
    localparam int unsigned WORD_N = 32;
    localparam int unsigned WORD_W = 5;

    // Register map, byte offsets inside the window
    localparam logic [OFF_W-1:0] PRIO_END  = 26'h000_1000;
    localparam logic [OFF_W-1:0] PEND_BASE = 26'h000_1000;
    localparam logic [OFF_W-1:0] PEND_END  = 26'h000_1080;
    localparam logic [OFF_W-1:0] ENA_BASE  = 26'h000_2000;
    localparam logic [OFF_W-1:0] ENA_END   = 26'h000_2100;
    localparam logic [OFF_W-1:0] CTX_BASE  = 26'h020_0000;

    // Context register select, offset bits [11:0]
    localparam logic [11:0] SEL_THRESH = 12'h000;
    localparam logic [11:0] SEL_CLAIM  = 12'h004;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_RAISE = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_PRIO_RD,
        ST_START,
        ST_SCAN,
        ST_DRAIN,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } t_rsp_push;

endpackage

// ----- rtl/core/pic_if.sv -----
// Request and response channel interfaces of the interrupt controller.
// Depends on pic_pkg for field widths.
interface pic_req_if import pic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [OFF_W-1:0]  reg_offset;
    logic [DATA_W-1:0] write_data;
    logic [SRC_W-1:0]  source_id;

    modport source (output valid, mode, reg_offset, write_data, source_id, input ready);
    modport sink   (input valid, mode, reg_offset, write_data, source_id, output ready);
endinterface

interface pic_rsp_if import pic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_out;

    modport source (output valid, read_data, irq_out, input ready);
    modport sink   (input valid, read_data, irq_out, output ready);
endinterface

// ----- rtl/core/pic_prio_mem.sv -----
// Source priority memory: one write port, one read port with registered data.
// Depends on pic_pkg for the data width.
module pic_prio_mem import pic_pkg::*; #(
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/pic_arb.sv -----
// Shared priority compare unit: keeps the best candidate seen during a scan.
// Depends on pic_pkg for the data width.
module pic_arb import pic_pkg::*; #(
    parameter int unsigned IDW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_thresh,
    input  logic              i_cand_valid,
    input  logic              i_cand_elig,
    input  logic [IDW-1:0]    i_cand_id,
    input  logic [DATA_W-1:0] i_prio,
    output logic [IDW-1:0]    o_best
);

    logic [DATA_W-1:0] r_top;
    logic [IDW-1:0]    r_best;
    logic              win;

    // strictly greater: ties keep the lower id seen first
    assign win = i_cand_valid && i_cand_elig && (i_prio > r_top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_best <= '0;
        end else if (i_start) begin
            r_top  <= i_thresh;
            r_best <= '0;
        end else if (win) begin
            r_top  <= i_prio;
            r_best <= i_cand_id;
        end
    end

    assign o_best = r_best;

endmodule

// ----- rtl/core/pic_ctrl.sv -----
// Sequencer of the interrupt controller: decodes bus accesses, holds pending,
// enable and threshold state and steps the source scan. Depends on pic_pkg.
module pic_ctrl import pic_pkg::*; #(
    parameter int unsigned NUM_SOURCES = 1024,
    localparam int unsigned IDW = $clog2(NUM_SOURCES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pic_req_if.sink           i_req,
    input  logic              i_out_free,
    output t_rsp_push         o_push,
    output logic              o_mem_we,
    output logic [IDW-1:0]    o_mem_waddr,
    output logic [DATA_W-1:0] o_mem_wdata,
    output logic [IDW-1:0]    o_mem_raddr,
    input  logic [DATA_W-1:0] i_mem_rdata,
    output logic              o_arb_start,
    output logic [DATA_W-1:0] o_arb_thresh,
    output logic              o_cand_valid,
    output logic              o_cand_elig,
    output logic [IDW-1:0]    o_cand_id,
    input  logic [IDW-1:0]    i_best
);

    localparam logic [IDW-1:0] LAST_ID   = IDW'(NUM_SOURCES - 1);
    localparam logic [SRC_W:0] NUM_SRC_X = (SRC_W + 1)'(NUM_SOURCES);

    t_state            r_state, n_state;
    logic [IDW-1:0]    r_cnt, n_cnt;
    logic [DATA_W-1:0] r_rd, n_rd;
    logic              r_claim, n_claim;
    t_mode             r_mode;
    logic [OFF_W-1:0]  r_off;
    logic [DATA_W-1:0] r_wdata;
    logic [SRC_W-1:0]  r_src;

    logic [DATA_W-1:0] r_pend [WORD_N];
    logic [DATA_W-1:0] r_ena  [WORD_N];
    logic [DATA_W-1:0] r_thresh;

    logic              r_cand_v;
    logic              r_cand_elig;
    logic [IDW-1:0]    r_cand_id;

    logic              is_prio, is_pend, is_ena, is_ctx;
    logic [11:0]       sel;
    logic [SRC_W-1:0]  bus_src;
    logic              src_ok, raise_ok;
    logic [WORD_W-1:0] bus_word, word_sel;
    logic [SRC_W-1:0]  cnt_ext, best_ext;
    logic [DATA_W-1:0] pend_word, ena_word;

    logic              ready, push_v;
    logic              ena_we, thr_we, pend_set, pend_clr;

    // Address decode of the latched access
    assign is_prio  = r_off < PRIO_END;
    assign is_pend  = (r_off >= PEND_BASE) && (r_off < PEND_END);
    assign is_ena   = (r_off >= ENA_BASE) && (r_off < ENA_END);
    assign is_ctx   = r_off >= CTX_BASE;
    assign sel      = r_off[11:0];
    assign bus_src  = r_off[11:2];
    assign bus_word = r_off[6:2];
    assign src_ok   = {1'b0, bus_src} < NUM_SRC_X;
    assign raise_ok = (r_src != '0) && ({1'b0, r_src} < NUM_SRC_X);

    assign cnt_ext  = SRC_W'(r_cnt);
    assign best_ext = SRC_W'(i_best);

    // one word read port on pending and enable, shared by bus and scan
    assign word_sel  = (r_state == ST_EXEC) ? bus_word : cnt_ext[SRC_W-1:WORD_W];
    assign pend_word = r_pend[word_sel];
    assign ena_word  = r_ena[word_sel];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_rd    <= '0;
            r_claim <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_rd    <= n_rd;
            r_claim <= n_claim;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_rd        = r_rd;
        n_claim     = r_claim;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_cnt;
        o_mem_wdata = '0;
        o_mem_raddr = r_cnt;
        o_arb_start = 1'b0;
        ready       = 1'b0;
        push_v      = 1'b0;
        ena_we      = 1'b0;
        thr_we      = 1'b0;
        pend_set    = 1'b0;
        pend_clr    = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // zero the priority memory once after reset
                o_mem_we = 1'b1;
                if (r_cnt == LAST_ID) begin
                    n_state = ST_IDLE;
                    n_cnt   = '0;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                ready = 1'b1;
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                    n_rd    = '0;
                    n_claim = 1'b0;
                end
            end
            ST_EXEC: begin
                o_mem_raddr = bus_src[IDW-1:0];
                n_state     = ST_START;
                unique case (r_mode)
                    MODE_READ: begin
                        priority if (is_prio) begin
                            n_state = ST_PRIO_RD;
                        end else if (is_pend) begin
                            n_rd = pend_word;
                        end else if (is_ena) begin
                            n_rd = ena_word;
                        end else if (is_ctx) begin
                            if (sel == SEL_THRESH) begin
                                n_rd = r_thresh;
                            end else if (sel == SEL_CLAIM) begin
                                n_claim = 1'b1;
                            end
                        end
                    end
                    MODE_WRITE: begin
                        priority if (is_prio) begin
                            o_mem_we    = (bus_src != '0) && src_ok;
                            o_mem_waddr = bus_src[IDW-1:0];
                            o_mem_wdata = r_wdata;
                        end else if (is_ena) begin
                            ena_we = 1'b1;
                        end else if (is_ctx) begin
                            thr_we = (sel == SEL_THRESH);
                        end
                    end
                    MODE_RAISE: begin
                        pend_set = raise_ok;
                    end
                    MODE_NONE: begin
                    end
                endcase
            end
            ST_PRIO_RD: begin
                n_rd    = src_ok ? i_mem_rdata : '0;
                n_state = ST_START;
            end
            ST_START: begin
                // load the threshold into the compare unit, scan from id 1
                o_arb_start = 1'b1;
                n_cnt       = IDW'(1);
                n_state     = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_cnt == LAST_ID) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_claim) begin
                    // claim: drop the winner's pending bit, rescan for the line
                    pend_clr = (i_best != '0);
                    n_rd     = DATA_W'(i_best);
                    n_claim  = 1'b0;
                    n_state  = ST_START;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    push_v  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // latch the accepted access
    always_ff @(posedge i_clk) begin
        if (ready && i_req.valid) begin
            r_mode  <= t_mode'(i_req.mode);
            r_off   <= i_req.reg_offset;
            r_wdata <= i_req.write_data;
            r_src   <= i_req.source_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WORD_N; i++) begin
                r_pend[i] <= '0;
                r_ena[i]  <= '0;
            end
            r_thresh <= '0;
        end else begin
            if (pend_set) begin
                r_pend[r_src[SRC_W-1:WORD_W]][r_src[WORD_W-1:0]] <= 1'b1;
            end
            if (pend_clr) begin
                r_pend[best_ext[SRC_W-1:WORD_W]][best_ext[WORD_W-1:0]] <= 1'b0;
            end
            if (ena_we) begin
                r_ena[bus_word] <= r_wdata;
            end
            if (thr_we) begin
                r_thresh <= r_wdata;
            end
        end
    end

    // candidate is registered so that it lines up with the registered memory data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_v <= 1'b0;
        end else begin
            r_cand_v <= (r_state == ST_SCAN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand_elig <= pend_word[cnt_ext[WORD_W-1:0]] & ena_word[cnt_ext[WORD_W-1:0]];
        r_cand_id   <= r_cnt;
    end

    assign i_req.ready  = ready;
    assign o_arb_thresh = r_thresh;
    assign o_cand_valid = r_cand_v;
    assign o_cand_elig  = r_cand_elig;
    assign o_cand_id    = r_cand_id;
    assign o_push       = '{valid: push_v, read_data: r_rd, irq: (i_best != '0)};

endmodule

// ----- rtl/core/platform_interrupt_controller_top.sv -----
// Platform interrupt controller, top level.
// Depends on pic_pkg, pic_if, pic_prio_mem, pic_arb and pic_ctrl.
//
// Usage:
//   i_req carries one bus access or source raise per transfer: mode selects
//   register read, register write or raise; reg_offset, write_data and
//   source_id are the operands. o_rsp returns one transfer per request with
//   read_data (register value, claimed id, or 0) and irq_out, the external
//   interrupt line as it stands after the request.
//   Each request is followed by a scan of sources 1 to NUM_SOURCES-1, one
//   source per cycle through the priority memory read port and the single
//   priority comparator. A priority read first passes through ST_PRIO_RD;
//   a claim read scans twice, once to pick the winner and once for the line
//   afterwards. One request is in flight at a time.
//   After reset the priority memory is cleared one entry per cycle, during
//   which i_req.ready stays low; all pending, enable and threshold state
//   resets to zero.
//   The response sits in an output register; if the receiver stalls, the
//   next request is still accepted and worked on, and its result waits until
//   the register frees.
module platform_interrupt_controller_top import pic_pkg::*; #(
    parameter int unsigned NUM_SOURCES = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pic_req_if.sink   i_req,
    pic_rsp_if.source o_rsp
);

    localparam int unsigned IDW = $clog2(NUM_SOURCES);

    logic              mem_we;
    logic [IDW-1:0]    mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [IDW-1:0]    mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              arb_start;
    logic [DATA_W-1:0] arb_thresh;
    logic              cand_valid;
    logic              cand_elig;
    logic [IDW-1:0]    cand_id;
    logic [IDW-1:0]    best;

    t_rsp_push         push;
    logic              out_free;

    logic              r_out_v;
    logic [DATA_W-1:0] r_out_rd;
    logic              r_out_irq;

    pic_prio_mem #(
        .DEPTH (NUM_SOURCES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pic_arb #(
        .IDW (IDW)
    ) u_arb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (arb_start),
        .i_thresh     (arb_thresh),
        .i_cand_valid (cand_valid),
        .i_cand_elig  (cand_elig),
        .i_cand_id    (cand_id),
        .i_prio       (mem_rdata),
        .o_best       (best)
    );

    pic_ctrl #(
        .NUM_SOURCES (NUM_SOURCES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata),
        .o_arb_start  (arb_start),
        .o_arb_thresh (arb_thresh),
        .o_cand_valid (cand_valid),
        .o_cand_elig  (cand_elig),
        .o_cand_id    (cand_id),
        .i_best       (best)
    );

    // output slot frees when empty or when its transfer completes this cycle
    assign out_free = !r_out_v || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (push.valid) begin
            r_out_v <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_v <= 1'b0;
        end
    end

    // hold the payload until a new result replaces it
    always_ff @(posedge i_clk) begin
        if (push.valid) begin
            r_out_rd  <= push.read_data;
            r_out_irq <= push.irq;
        end
    end

    assign o_rsp.valid     = r_out_v;
    assign o_rsp.read_data = r_out_rd;
    assign o_rsp.irq_out   = r_out_irq;

endmodule

// ----- dv/platform_interrupt_controller_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for platform_interrupt_controller_top.
// Drives register reads, writes and source raises, predicts each response and
// checks it. Depends on pic_pkg and the pic_req_if / pic_rsp_if interfaces.
module platform_interrupt_controller_top_test;
    import pic_pkg::*;

    localparam int unsigned NUM_SRC       = 1024;
    localparam int unsigned POOL_N        = 16;
    // A claim scans the sources twice; leave room for one more after the last response.
    localparam int unsigned SETTLE_CYCLES = 2 * NUM_SRC + 200;
    localparam int unsigned HOLD_CYCLES   = 4000;
    localparam int unsigned CYCLE_LIMIT   = 5_000_000;

    // One bus access or source raise, as offered on the request channel.
    typedef struct {
        t_mode              mode;
        logic [OFF_W-1:0]   off;
        logic [DATA_W-1:0]  wdata;
        logic [SRC_W-1:0]   src;
    } t_bus_op;

    // What one response transfer must carry.
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    pic_req_if req_bus ();
    pic_rsp_if rsp_bus ();

    platform_interrupt_controller_top #(
        .NUM_SOURCES (NUM_SRC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus)
    );

    // Shadow copy of the controller state, advanced in acceptance order.
    logic [DATA_W-1:0] prio_tbl [NUM_SRC];
    logic [DATA_W-1:0] pend_tbl [WORD_N];
    logic [DATA_W-1:0] ena_tbl  [WORD_N];
    logic [DATA_W-1:0] thresh_val;

    // Responses still owed by the block, oldest first.
    t_outcome awaited_rsp [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned hold_request;
    bit          src_gaps_on;
    bit          sink_stalls_on;
    logic [SRC_W-1:0] src_pool [POOL_N];

    // ------------------------------------------------------------------
    // Clock, and a hard stop in case the block hangs.
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("platform_interrupt_controller_top_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Highest-priority pending and enabled source above the threshold; lowest
    // id wins a tie because only a strictly higher priority replaces the pick.
    function automatic logic [SRC_W-1:0] winning_source();
        logic [SRC_W-1:0]  best;
        logic [DATA_W-1:0] top;
        logic [SRC_W-1:0]  idx;
        best = '0;
        top  = thresh_val;
        for (int id = 1; id < NUM_SRC; id++) begin
            idx = id[SRC_W-1:0];
            if (pend_tbl[idx[9:5]][idx[4:0]] && ena_tbl[idx[9:5]][idx[4:0]] &&
                prio_tbl[idx] > top) begin
                top  = prio_tbl[idx];
                best = idx;
            end
        end
        return best;
    endfunction

    // Apply one access to the shadow state and return the response it owes.
    function automatic t_outcome predict_access(t_bus_op op);
        t_outcome         res;
        logic [SRC_W-1:0] won;
        logic [11:0]      sel;
        res.read_data = '0;
        sel = op.off[11:0];
        case (op.mode)
            MODE_READ: begin
                if (op.off < PRIO_END) begin
                    res.read_data = prio_tbl[op.off[11:2]];
                end else if (op.off >= PEND_BASE && op.off < PEND_END) begin
                    res.read_data = pend_tbl[op.off[6:2]];
                end else if (op.off >= ENA_BASE && op.off < ENA_END) begin
                    // Upper half of the enable window aliases the lower half.
                    res.read_data = ena_tbl[op.off[6:2]];
                end else if (op.off >= CTX_BASE) begin
                    if (sel == SEL_THRESH) begin
                        res.read_data = thresh_val;
                    end else if (sel == SEL_CLAIM) begin
                        won = winning_source();
                        if (won != '0) begin
                            pend_tbl[won[9:5]][won[4:0]] = 1'b0;
                        end
                        res.read_data = DATA_W'(won);
                    end
                end
            end
            MODE_WRITE: begin
                if (op.off < PRIO_END) begin
                    // Source zero has a hardwired priority of zero.
                    if (op.off[11:2] != '0) begin
                        prio_tbl[op.off[11:2]] = op.wdata;
                    end
                end else if (op.off >= ENA_BASE && op.off < ENA_END) begin
                    ena_tbl[op.off[6:2]] = op.wdata;
                end else if (op.off >= CTX_BASE && sel == SEL_THRESH) begin
                    thresh_val = op.wdata;
                end
                // Pending words, complete and unmapped offsets drop the write.
            end
            MODE_RAISE: begin
                if (op.src != '0) begin
                    pend_tbl[op.src[9:5]][op.src[4:0]] = 1'b1;
                end
            end
            MODE_NONE: begin
            end
            default: begin
            end
        endcase
        res.irq = (winning_source() != '0);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    function automatic t_bus_op make_op(t_mode mode, logic [OFF_W-1:0] off,
                                        logic [DATA_W-1:0] wdata, logic [SRC_W-1:0] src);
        t_bus_op op;
        op.mode  = mode;
        op.off   = off;
        op.wdata = wdata;
        op.src   = src;
        return op;
    endfunction

    // Offer one transfer, hold it until accepted, then record its response.
    // Valid is left high so a back-to-back transfer needs no second drive.
    task automatic send_op(input t_bus_op op);
        int gap;
        if (src_gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_bus.valid      <= 1'b1;
        req_bus.mode       <= op.mode;
        req_bus.reg_offset <= op.off;
        req_bus.write_data <= op.wdata;
        req_bus.source_id  <= op.src;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
        awaited_rsp.push_back(predict_access(op));
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic drain_responses();
        req_bus.valid <= 1'b0;
        while (awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    // Pick the sources most traffic goes to: the two extreme ids, a cluster
    // sharing a few pending words, and some scattered ones.
    task automatic refresh_source_pool();
        int base;
        base = $urandom_range(0, 27);
        src_pool[0] = SRC_W'(1);
        src_pool[1] = SRC_W'(NUM_SRC - 1);
        for (int k = 2; k < POOL_N; k++) begin
            if (k < 10) begin
                src_pool[k] = SRC_W'(base * 32 + $urandom_range(1, 63));
            end else begin
                src_pool[k] = SRC_W'($urandom_range(1, NUM_SRC - 1));
            end
        end
    endtask

    function automatic logic [SRC_W-1:0] pool_source();
        return src_pool[$urandom_range(0, POOL_N - 1)];
    endfunction

    function automatic logic [DATA_W-1:0] random_priority();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 75) return DATA_W'($urandom_range(0, 7));
        if (roll < 88) return DATA_W'($urandom_range(0, 15));
        if (roll < 93) return '1;
        return $urandom;
    endfunction

    // Mostly well-formed traffic around the source pool: prioritize, enable,
    // raise and claim, with a share of odd offsets and idle modes mixed in.
    // Unused operands are always random to show they are ignored.
    function automatic t_bus_op random_op();
        t_bus_op          op;
        int               pick;
        logic [SRC_W-1:0] s;
        logic [11:0]      sel;
        pick     = $urandom_range(0, 99);
        s        = pool_source();
        op.mode  = MODE_READ;
        op.off   = OFF_W'($urandom_range(0, 26'h3FF_FFFF));
        op.wdata = $urandom;
        op.src   = SRC_W'($urandom_range(0, NUM_SRC - 1));
        if (pick < 18) begin
            op.mode = MODE_RAISE;
            op.src  = s;
        end else if (pick < 22) begin
            op.mode = MODE_RAISE;
        end else if (pick < 34) begin
            op.mode  = MODE_WRITE;
            op.off   = OFF_W'({s, 2'($urandom_range(0, 3))});
            op.wdata = random_priority();
        end else if (pick < 38) begin
            op.mode = MODE_WRITE;
            op.off  = OFF_W'($urandom_range(0, 12'hFFF));
        end else if (pick < 44) begin
            op.off = ($urandom_range(0, 1) == 0) ? OFF_W'({s, 2'b00})
                                                 : OFF_W'($urandom_range(0, 12'hFFF));
        end else if (pick < 50) begin
            // Enable the word holding a pool source, through either alias.
            op.mode  = MODE_WRITE;
            op.off   = ENA_BASE + OFF_W'({1'($urandom_range(0, 1)), s[9:5],
                                          2'($urandom_range(0, 3))});
            op.wdata = ($urandom_range(0, 2) == 0) ? '1 : $urandom;
        end else if (pick < 54) begin
            op.off = ENA_BASE + OFF_W'($urandom_range(0, 8'hFF));
        end else if (pick < 58) begin
            op.off = PEND_BASE + OFF_W'($urandom_range(0, 7'h7F));
        end else if (pick < 60) begin
            op.mode = MODE_WRITE;
            op.off  = PEND_BASE + OFF_W'($urandom_range(0, 7'h7F));
        end else if (pick < 76) begin
            // Claim, either at the base of the context window or higher up.
            op.off = CTX_BASE + OFF_W'(SEL_CLAIM);
            if ($urandom_range(0, 1) == 0) begin
                op.off = CTX_BASE | OFF_W'({14'($urandom), SEL_CLAIM});
            end
        end else if (pick < 78) begin
            op.mode = MODE_WRITE;
            op.off  = CTX_BASE | OFF_W'({14'($urandom), SEL_CLAIM});
        end else if (pick < 82) begin
            op.mode  = MODE_WRITE;
            op.off   = CTX_BASE | OFF_W'({14'($urandom), SEL_THRESH});
            op.wdata = ($urandom_range(0, 9) == 0) ? $urandom : DATA_W'($urandom_range(0, 4));
        end else if (pick < 85) begin
            op.off = CTX_BASE | OFF_W'({14'($urandom), SEL_THRESH});
        end else if (pick < 89) begin
            // Any other context select is unmapped.
            sel = 12'($urandom_range(1, 12'hFFF));
            if (sel == SEL_CLAIM) sel = 12'h008;
            op.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
            op.off  = CTX_BASE | OFF_W'({14'($urandom), sel});
        end else if (pick < 94) begin
            op.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
        end else if (pick < 97) begin
            // Gaps between the mapped regions.
            op.mode = ($urandom_range(0, 1) == 0) ? MODE_READ : MODE_WRITE;
            op.off  = ($urandom_range(0, 1) == 0) ?
                      OFF_W'($urandom_range(26'h1080, 26'h1FFF)) :
                      OFF_W'($urandom_range(26'h2100, 26'h1F_FFFF));
        end else begin
            op.mode = MODE_NONE;
        end
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Response side: check every transfer, stall at random, and run the
    // long hold-off when a test asks for one.
    // ------------------------------------------------------------------
    task automatic check_response();
        t_outcome want;
        if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response read_data %h irq_out %b",
                     $time, rsp_bus.read_data, rsp_bus.irq_out);
            mismatch_count++;
        end else begin
            want = awaited_rsp.pop_front();
            if (rsp_bus.read_data !== want.read_data) begin
                $display("%0t: read_data expected %h actual %h",
                         $time, want.read_data, rsp_bus.read_data);
                mismatch_count++;
            end
            if (rsp_bus.irq_out !== want.irq) begin
                $display("%0t: irq_out expected %b actual %b",
                         $time, want.irq, rsp_bus.irq_out);
                mismatch_count++;
            end
        end
    endtask

    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
                check_response();
            end
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_bus.ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else if (sink_stalls_on && $urandom_range(0, 5) == 0) begin
                stall_left    = $urandom_range(1, 10) - 1;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walk the register map once: reset values, source zero, the top source,
    // enable aliasing, ignored pending writes, threshold extremes, claim order
    // with a tie, complete, unmapped offsets and the idle mode.
    task automatic test_directed_map();
        logic [OFF_W-1:0] claim_off;
        claim_off = CTX_BASE + OFF_W'(SEL_CLAIM);
        send_op(make_op(MODE_READ,  26'h0,            '1,            10'h3FF));
        send_op(make_op(MODE_WRITE, 26'h0,            '1,            10'h0));
        send_op(make_op(MODE_READ,  26'h3,            '0,            10'h0));
        send_op(make_op(MODE_WRITE, 26'hFFC,          '1,            10'h0));
        send_op(make_op(MODE_WRITE, 26'h14,           32'd3,         10'h0));
        send_op(make_op(MODE_WRITE, 26'h1C,           32'd3,         10'h0));
        send_op(make_op(MODE_WRITE, ENA_BASE + 26'h80, '1,           10'h0));
        send_op(make_op(MODE_WRITE, ENA_BASE + 26'hFF, 32'h8000_0000, 10'h0));
        send_op(make_op(MODE_READ,  ENA_BASE,         '0,            10'h0));
        send_op(make_op(MODE_RAISE, 26'h0,            '1,            10'h0));
        send_op(make_op(MODE_RAISE, 26'h3FF_FFFF,     '1,            10'h3FF));
        send_op(make_op(MODE_RAISE, 26'h0,            '0,            10'd7));
        send_op(make_op(MODE_RAISE, 26'h0,            '0,            10'd5));
        send_op(make_op(MODE_WRITE, PEND_BASE,        '0,            10'h0));
        send_op(make_op(MODE_READ,  PEND_END - 26'd4, '0,            10'h0));
        send_op(make_op(MODE_WRITE, CTX_BASE,         32'd2,         10'h0));
        send_op(make_op(MODE_READ,  26'h3FF_F000,     '0,            10'h0));
        send_op(make_op(MODE_READ,  claim_off,        '0,            10'h0));
        send_op(make_op(MODE_READ,  claim_off,        '0,            10'h0));
        send_op(make_op(MODE_WRITE, claim_off,        32'd5,         10'h0));
        send_op(make_op(MODE_WRITE, CTX_BASE,         '1,            10'h0));
        send_op(make_op(MODE_READ,  claim_off,        '0,            10'h0));
        send_op(make_op(MODE_READ,  PEND_END,         '1,            10'h3FF));
        send_op(make_op(MODE_NONE,  26'h3FF_FFFF,     '1,            10'h3FF));
        send_op(make_op(MODE_WRITE, CTX_BASE,         '0,            10'h0));
        send_op(make_op(MODE_READ,  claim_off,        '0,            10'h0));
    endtask

    // Random traffic around one pool of sources.
    task automatic test_claim_traffic(input int unsigned count);
        refresh_source_pool();
        repeat (count) send_op(random_op());
    endtask

    // Hold the response side off long enough that the output register and the
    // request in flight both fill, while requests keep coming.
    task automatic test_output_backpressure();
        src_gaps_on  = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (6) send_op(random_op());
        src_gaps_on  = 1'b1;
    endtask

    // Stop sending until every response is back, then carry on.
    task automatic test_drain_pause();
        refresh_source_pool();
        repeat (20) send_op(random_op());
        drain_responses();
        repeat (20) send_op(random_op());
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming(input int unsigned count);
        src_gaps_on    = 1'b0;
        sink_stalls_on = 1'b0;
        refresh_source_pool();
        repeat (count) send_op(random_op());
    endtask

    initial begin
        mismatch_count = 0;
        hold_request   = 0;
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
        for (int k = 0; k < NUM_SRC; k++) prio_tbl[k] = '0;
        for (int k = 0; k < WORD_N; k++) begin
            pend_tbl[k] = '0;
            ena_tbl[k]  = '0;
        end
        thresh_val = '0;

        // Drive every request input from the start while reset is held.
        i_rst_n            <= 1'b0;
        req_bus.valid      <= 1'b0;
        req_bus.mode       <= MODE_NONE;
        req_bus.reg_offset <= '0;
        req_bus.write_data <= '0;
        req_bus.source_id  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_map();
        test_claim_traffic(200);
        test_output_backpressure();
        test_drain_pause();
        test_claim_traffic(250);
        test_streaming(80);

        drain_responses();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("platform_interrupt_controller_top_test: clean");
        end else begin
            $display("platform_interrupt_controller_top_test: errors");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pic_pkg.sv
rtl/core/pic_if.sv
rtl/core/pic_prio_mem.sv
rtl/core/pic_arb.sv
rtl/core/pic_ctrl.sv
rtl/core/platform_interrupt_controller_top.sv
dv/platform_interrupt_controller_top_test.sv
